// File: src/dvvr_pkg.sv
`timescale 1ns / 1ps
package dvvr_pkg;

  localparam int MAX_ROWS_DEF   = 1024;
  localparam int MAX_VALUES_DEF = 4096;
  localparam int Q_DEPTH        = 2;
  localparam int Q_AW           = $clog2(Q_DEPTH);
  localparam int SUM_W          = 36;

  localparam logic [1:0] ACT_LOAD_DEV = 2'd0;
  localparam logic [1:0] ACT_LOAD_TS  = 2'd1;
  localparam logic [1:0] ACT_QUERY    = 2'd2;

  // classified command kinds
  localparam logic [1:0] K_LOAD_DEV  = 2'd0;
  localparam logic [1:0] K_LOAD_TS   = 2'd1;
  localparam logic [1:0] K_QUERY     = 2'd2;
  localparam logic [1:0] K_QUERY_ERR = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] entry_index;
    logic [31:0] entry_value;
    logic [9:0]  row_number;
    logic        use_bound;
    logic [31:0] timestamp_bound;
  } in_word_t;

  typedef struct packed {
    logic [31:0] range_begin;
    logic [31:0] range_end;
    logic [31:0] value_count;
    logic        status;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] entry_index;
    logic [31:0] entry_value;
    logic [9:0]  row_number;
    logic        use_bound;
    logic [31:0] timestamp_bound;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_q_t;

  function automatic logic signed [SUM_W-1:0] zigzag_decode(input logic [31:0] u);
    logic [31:0] d;
    d = (u >> 1) ^ {32{u[0]}};
    return {{(SUM_W-32){d[31]}}, d};
  endfunction

endpackage

// File: src/dvvr_front.sv
`timescale 1ns / 1ps
module dvvr_front #(
  parameter int MAX_ROWS   = dvvr_pkg::MAX_ROWS_DEF,
  parameter int MAX_VALUES = dvvr_pkg::MAX_VALUES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  dvvr_pkg::in_word_t  in_data,
  output dvvr_pkg::cmd_q_t    q_head,
  input  logic                q_pop
);

  localparam int CNT_W = $clog2(dvvr_pkg::Q_DEPTH + 1);

  dvvr_pkg::cmd_t q_mem [dvvr_pkg::Q_DEPTH];
  logic [dvvr_pkg::Q_AW-1:0] head;
  logic [dvvr_pkg::Q_AW-1:0] tail;
  logic [CNT_W-1:0]          count;

  dvvr_pkg::cmd_t cmd_in;
  logic           keep;
  logic           wr;
  logic           rd;

  // classify: unused action and out-of-store loads are dropped here
  always_comb begin
    cmd_in.kind            = dvvr_pkg::K_QUERY;
    cmd_in.entry_index     = in_data.entry_index;
    cmd_in.entry_value     = in_data.entry_value;
    cmd_in.row_number      = in_data.row_number;
    cmd_in.use_bound       = in_data.use_bound;
    cmd_in.timestamp_bound = in_data.timestamp_bound;
    keep                   = 1'b0;
    case (in_data.action)
      dvvr_pkg::ACT_LOAD_DEV: begin
        cmd_in.kind = dvvr_pkg::K_LOAD_DEV;
        keep        = 32'(in_data.entry_index) < 32'(MAX_ROWS);
      end
      dvvr_pkg::ACT_LOAD_TS: begin
        cmd_in.kind = dvvr_pkg::K_LOAD_TS;
        keep        = 32'(in_data.entry_index) < 32'(MAX_VALUES);
      end
      dvvr_pkg::ACT_QUERY: begin
        keep = 1'b1;
        if (32'(in_data.row_number) >= 32'(MAX_ROWS)) begin
          cmd_in.kind = dvvr_pkg::K_QUERY_ERR;
        end
      end
      default: keep = 1'b0;
    endcase
  end

  assign full         = (count == CNT_W'(dvvr_pkg::Q_DEPTH));
  assign wr           = push && !full && keep;
  assign rd           = q_pop && (count != '0);
  assign q_head.valid = (count != '0);
  assign q_head.cmd   = q_mem[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        tail <= tail + 1'b1;
      end
      if (rd) begin
        head <= head + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_mem[tail] <= cmd_in;
    end
  end

endmodule

// File: src/dvvr_back.sv
`timescale 1ns / 1ps
module dvvr_back #(
  parameter int MAX_ROWS   = dvvr_pkg::MAX_ROWS_DEF,
  parameter int MAX_VALUES = dvvr_pkg::MAX_VALUES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [15:0]         cfg_write_data,
  input  dvvr_pkg::cmd_q_t    q_head,
  output logic                q_pop,
  output logic                out_valid,
  output dvvr_pkg::out_word_t out_data,
  input  logic                out_take
);

  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int TS_AW  = $clog2(MAX_VALUES);
  localparam int VAL_W  = $clog2(MAX_VALUES + 1);
  localparam int PROD_W = 27;
  localparam int SW     = dvvr_pkg::SUM_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LO    = 3'd1;
  localparam logic [2:0] S_HI    = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_START = 3'd4;
  localparam logic [2:0] S_SRCH  = 3'd5;

  logic [2:0]  state;
  logic [15:0] evpr;
  dvvr_pkg::cmd_t cmd;

  logic [31:0] dev_mem [MAX_ROWS];
  logic [31:0] ts_mem  [MAX_VALUES];
  logic [31:0] dev_q;
  logic [31:0] ts_q;
  logic [ROW_AW-1:0] dev_raddr;
  logic [TS_AW-1:0]  ts_raddr;
  logic dev_we;
  logic ts_we;

  logic [PROD_W-1:0]    base_lo;
  logic [PROD_W-1:0]    base_hi;
  logic signed [SW-1:0] lo;
  logic signed [SW-1:0] hi;
  logic signed [SW-1:0] span;
  logic [VAL_W-1:0] first;
  logic [VAL_W-1:0] cnt;
  logic [VAL_W-1:0] mid;

  logic             start;
  logic             bad;
  logic             less;
  logic [VAL_W-1:0] step;
  logic [VAL_W-1:0] first_next;
  logic [VAL_W-1:0] cnt_next;
  logic [VAL_W-1:0] mid_next;
  logic [VAL_W-1:0] mid_start;

  assign start  = (state == S_IDLE) && q_head.valid;
  assign q_pop  = start && (q_head.cmd.kind == dvvr_pkg::K_LOAD_DEV ||
                            q_head.cmd.kind == dvvr_pkg::K_LOAD_TS || !out_valid);
  assign dev_we = q_pop && (q_head.cmd.kind == dvvr_pkg::K_LOAD_DEV);
  assign ts_we  = q_pop && (q_head.cmd.kind == dvvr_pkg::K_LOAD_TS);

  assign span = hi - lo;
  assign bad  = lo[SW-1] || hi[SW-1] || (lo > SW'(MAX_VALUES)) || (hi > SW'(MAX_VALUES));

  // one lower-bound step per cycle; next probe address issued in the same cycle
  assign step       = cnt >> 1;
  assign less       = ts_q < cmd.timestamp_bound;
  assign first_next = less ? mid + VAL_W'(1) : first;
  assign cnt_next   = less ? cnt - step - VAL_W'(1) : step;
  assign mid_next   = first_next + (cnt_next >> 1);
  assign mid_start  = first + (cnt >> 1);

  always_comb begin
    if (state == S_IDLE) begin
      if (q_head.cmd.row_number == 10'd0) begin
        dev_raddr = ROW_AW'(q_head.cmd.row_number);
      end else begin
        dev_raddr = ROW_AW'(q_head.cmd.row_number - 10'd1);
      end
    end else begin
      dev_raddr = ROW_AW'(cmd.row_number);
    end
    if (state == S_START) begin
      ts_raddr = TS_AW'(mid_start);
    end else begin
      ts_raddr = TS_AW'(mid_next);
    end
  end

  always_ff @(posedge clk) begin
    if (dev_we) begin
      dev_mem[ROW_AW'(q_head.cmd.entry_index)] <= q_head.cmd.entry_value;
    end
    if (ts_we) begin
      ts_mem[TS_AW'(q_head.cmd.entry_index)] <= q_head.cmd.entry_value;
    end
    dev_q <= dev_mem[dev_raddr];
    ts_q  <= ts_mem[ts_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      evpr      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        evpr <= cfg_write_data;
      end
      if (out_take && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (q_head.cmd.kind == dvvr_pkg::K_QUERY_ERR) begin
              out_valid <= 1'b1;
            end else if (q_head.cmd.kind == dvvr_pkg::K_QUERY) begin
              state <= S_LO;
            end
          end
        end
        S_LO:    state <= S_HI;
        S_HI:    state <= S_CHK;
        S_CHK: begin
          if (!bad && cmd.use_bound && (hi > lo)) begin
            state <= S_START;
          end else begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_START: state <= S_SRCH;
        S_SRCH: begin
          if (cnt_next == '0) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd     <= q_head.cmd;
        base_lo <= PROD_W'(evpr) * PROD_W'(q_head.cmd.row_number);
        if (q_pop && q_head.cmd.kind == dvvr_pkg::K_QUERY_ERR) begin
          out_data <= '{range_begin: 32'd0, range_end: 32'd0,
                        value_count: 32'd0, status: 1'b1};
        end
      end
      S_LO: begin
        // row 0 starts at zero; dev_q holds the previous row's deviation
        if (cmd.row_number == 10'd0) begin
          lo <= '0;
        end else begin
          lo <= SW'(base_lo) + dvvr_pkg::zigzag_decode(dev_q);
        end
        base_hi <= base_lo + PROD_W'(evpr);
      end
      S_HI: begin
        hi <= SW'(base_hi) + dvvr_pkg::zigzag_decode(dev_q);
      end
      S_CHK: begin
        out_data.range_begin <= lo[31:0];
        out_data.range_end   <= hi[31:0];
        out_data.value_count <= span[31:0];
        out_data.status      <= bad;
        first                <= VAL_W'(lo);
        cnt                  <= VAL_W'(span);
      end
      S_START: begin
        mid <= mid_start;
      end
      S_SRCH: begin
        first <= first_next;
        cnt   <= cnt_next;
        mid   <= mid_next;
        out_data.range_begin <= 32'(first_next);
      end
      default: begin
        mid <= mid;
      end
    endcase
  end

endmodule

// File: src/dense_version_value_range_unit.sv
`timescale 1ns / 1ps
// Loads pass the front queue and retire one per cycle in the back unit while it is idle.
// A query result is registered after states LO, HI and CHK (from IDLE if the row is past
// the table); bound search adds START and SRCH steps (at most log2(MAX_VALUES)+1 steps).
// One query at a time: the next one starts after the previous result is popped.
// Reset (rst, synchronous): queue and result emptied, values-per-row register
// cleared; the two tables are not cleared and read undefined until loaded.
module dense_version_value_range_unit #(
  parameter int MAX_ROWS   = dvvr_pkg::MAX_ROWS_DEF,
  parameter int MAX_VALUES = dvvr_pkg::MAX_VALUES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  dvvr_pkg::in_word_t  in_data,
  output logic                empty,
  input  logic                pop,
  output dvvr_pkg::out_word_t out_data,
  input  logic                cfg_write_en,
  input  logic [15:0]         cfg_write_data
);

  dvvr_pkg::cmd_q_t q_head;
  logic             q_pop;
  logic             out_valid;

  dvvr_front #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_VALUES (MAX_VALUES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  dvvr_back #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_VALUES (MAX_VALUES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .out_take       (pop)
  );

  assign empty = !out_valid;

endmodule

// File: tb/tb_dense_version_value_range_unit.sv
`timescale 1ns / 1ps
module tb_dense_version_value_range_unit;

  localparam int ROWS        = dvvr_pkg::MAX_ROWS_DEF;
  localparam int VALUES      = dvvr_pkg::MAX_VALUES_DEF;
  localparam int ITEMS       = 1900;
  localparam int PHASES      = 8;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 500;
  localparam int SETTLE      = 40;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // predicts the row range of each query from its own copy of both tables
  class range_scoreboard;
    bit [15:0] values_per_row;
    bit [31:0] dev_tab [ROWS];
    bit [31:0] ts_tab [VALUES];
    bit        dev_set [ROWS];
    bit        ts_set [VALUES];
    dvvr_pkg::out_word_t want_q [$];
    int        errors;

    function void set_config(bit [15:0] v);
      values_per_row = v;
    endfunction

    function longint unzig(bit [31:0] u);
      longint half;
      half = longint'(u >> 1);
      return u[0] ? -half - 1 : half;
    endfunction

    function bit row_start(int r, output longint s);
      s = 0;
      if (r == 0) return 1'b1;
      if (r - 1 >= ROWS) return 1'b0;
      s = longint'(values_per_row) * longint'(r) + unzig(dev_tab[r - 1]);
      return 1'b1;
    endfunction

    // miss: first timestamp slot on the search path that was never loaded, or -1
    function dvvr_pkg::out_word_t predict(dvvr_pkg::in_word_t w, output int miss);
      longint lo, hi, first, count, step, mid;
      bit ok_lo, ok_hi;
      dvvr_pkg::out_word_t o;
      miss = -1;
      o = '0;
      ok_lo = row_start(int'(w.row_number), lo);
      ok_hi = row_start(int'(w.row_number) + 1, hi);
      if (!(ok_lo && ok_hi)) begin
        o.status = 1'b1;
        return o;
      end
      o.value_count = 32'(hi - lo);
      o.range_end   = 32'(hi);
      if (lo < 0 || hi < 0 || lo > VALUES || hi > VALUES) begin
        o.range_begin = 32'(lo);
        o.status      = 1'b1;
        return o;
      end
      first = lo;
      if (w.use_bound && hi > lo) begin
        count = hi - lo;
        while (count > 0) begin
          step = count / 2;
          mid  = first + step;
          if (!ts_set[mid] && miss < 0) miss = int'(mid);
          if (ts_tab[mid] < w.timestamp_bound) begin
            first = mid + 1;
            count -= step + 1;
          end else begin
            count = step;
          end
        end
      end
      o.range_begin = 32'(first);
      return o;
    endfunction

    function void note_input(dvvr_pkg::in_word_t w);
      int miss;
      case (w.action)
        dvvr_pkg::ACT_LOAD_DEV: begin
          if (w.entry_index < ROWS) begin
            dev_tab[w.entry_index] = w.entry_value;
            dev_set[w.entry_index] = 1'b1;
          end
        end
        dvvr_pkg::ACT_LOAD_TS: begin
          if (w.entry_index < VALUES) begin
            ts_tab[w.entry_index] = w.entry_value;
            ts_set[w.entry_index] = 1'b1;
          end
        end
        dvvr_pkg::ACT_QUERY: want_q.push_back(predict(w, miss));
        default: ;
      endcase
    endfunction

    function void check_result(dvvr_pkg::out_word_t got);
      dvvr_pkg::out_word_t want;
      if (want_q.size() == 0) begin
        $error("unexpected result word: %h", got);
        errors++;
        return;
      end
      want = want_q.pop_front();
      if (got.range_begin !== want.range_begin) begin
        $error("range_begin: expected %0d, got %0d", want.range_begin, got.range_begin);
        errors++;
      end
      if (got.range_end !== want.range_end) begin
        $error("range_end: expected %0d, got %0d", want.range_end, got.range_end);
        errors++;
      end
      if (got.value_count !== want.value_count) begin
        $error("value_count: expected %0d, got %0d", want.value_count, got.value_count);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                push;
  logic                full;
  dvvr_pkg::in_word_t  in_data;
  logic                empty;
  logic                pop;
  dvvr_pkg::out_word_t out_data;
  logic                cfg_write_en;
  logic [15:0]         cfg_write_data;

  range_scoreboard sb = new();
  int  sent;
  bit  burst;
  bit  hold_req;
  bit  hold_done;
  int  stall_cycles;

  dense_version_value_range_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .in_data       (in_data),
    .empty         (empty),
    .pop           (pop),
    .out_data      (out_data),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic dvvr_pkg::in_word_t rand_fields();
    dvvr_pkg::in_word_t w;
    w.action          = 2'($urandom);
    w.entry_index     = 12'($urandom);
    w.entry_value     = $urandom;
    w.row_number      = 10'($urandom);
    w.use_bound       = 1'($urandom);
    w.timestamp_bound = $urandom;
    return w;
  endfunction

  // mostly small signed deviations, zigzag coded
  function automatic bit [31:0] small_dev();
    int d;
    if ($urandom_range(0, 9) == 0) return $urandom;
    d = $urandom_range(0, 12) - 6;
    return (d >= 0) ? 32'(2 * d) : 32'(-2 * d - 1);
  endfunction

  // roughly ascending along the table so the search has something to find
  function automatic bit [31:0] ts_val(int idx);
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'(idx / 8 + $urandom_range(0, 15));
  endfunction

  function automatic bit [31:0] pick_bound();
    int r;
    r = $urandom_range(0, 15);
    if (r < 2) return $urandom;
    if (r == 2) return 32'd0;
    if (r == 3) return 32'hFFFF_FFFF;
    return 32'($urandom_range(0, 560));
  endfunction

  function automatic int pick_row();
    int lim;
    if (sb.values_per_row == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, ROWS - 1);
    lim = VALUES / sb.values_per_row + 2;
    if (lim > ROWS - 1) lim = ROWS - 1;
    return $urandom_range(0, lim);
  endfunction

  // push stays high on return; pace() or cfg_set() lowers it
  task automatic send_word(dvvr_pkg::in_word_t w);
    in_data <= w;
    push    <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_input(w);
    if (w.action != ACT_UNUSED &&
        !(w.action == dvvr_pkg::ACT_LOAD_DEV && w.entry_index >= ROWS))
      sent++;
  endtask

  task automatic pace();
    int g;
    if (burst) return;
    if ($urandom_range(0, 199) == 0) begin
      push <= 1'b0;
      do @(posedge clk); while (sb.pending() != 0);
      return;
    end
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic cfg_set(bit [15:0] v);
    push <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    // loads give no result word, so let the back unit retire them
    repeat (SETTLE) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    sb.set_config(v);
    cfg_write_en <= 1'b0;
  endtask

  task automatic load(logic [1:0] act, int idx, bit [31:0] v);
    dvvr_pkg::in_word_t w;
    w             = rand_fields();
    w.action      = act;
    w.entry_index = 12'(idx);
    w.entry_value = v;
    send_word(w);
    pace();
  endtask

  task automatic send_other();
    dvvr_pkg::in_word_t w;
    w        = rand_fields();
    w.action = ACT_UNUSED;
    send_word(w);
    pace();
  endtask

  // loads whatever the query will read and has never been written, then queries
  task automatic query(int row, bit ub, bit [31:0] bound);
    dvvr_pkg::in_word_t w;
    int miss;
    w                 = rand_fields();
    w.action          = dvvr_pkg::ACT_QUERY;
    w.row_number      = 10'(row);
    w.use_bound       = ub;
    w.timestamp_bound = bound;
    if (row > 0 && !sb.dev_set[row - 1]) load(dvvr_pkg::ACT_LOAD_DEV, row - 1, small_dev());
    if (!sb.dev_set[row]) load(dvvr_pkg::ACT_LOAD_DEV, row, small_dev());
    void'(sb.predict(w, miss));
    while (miss >= 0) begin
      load(dvvr_pkg::ACT_LOAD_TS, miss, ts_val(miss));
      void'(sb.predict(w, miss));
    end
    send_word(w);
    pace();
  endtask

  task automatic random_step();
    int r;
    int idx;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      query(pick_row(), $urandom_range(0, 3) != 0, pick_bound());
    end else if (r < 70) begin
      load(dvvr_pkg::ACT_LOAD_DEV, pick_row(), small_dev());
    end else if (r < 85) begin
      idx = $urandom_range(0, VALUES - 1);
      load(dvvr_pkg::ACT_LOAD_TS, idx, ts_val(idx));
    end else if (r < 90) begin
      load(dvvr_pkg::ACT_LOAD_DEV, $urandom_range(ROWS, 4095), $urandom);
    end else if (r < 94) begin
      send_other();
    end else begin
      load(dvvr_pkg::ACT_LOAD_DEV, $urandom_range(0, ROWS - 1), $urandom);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("dense_version_value_range_unit: mismatch");
        $finish;
      end
    end
  end

  // result side: mostly draining, random gaps, one long hold on request
  initial begin
    int run;
    int g;
    pop = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        pop <= 1'b1;
        run = $urandom_range(1, 30);
        repeat (run) @(posedge clk);
        g = gap_len();
        if (g > 0) begin
          pop <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  initial begin
    bit [15:0] phase_cfg [PHASES];
    int phase_end;
    rst            = 1'b1;
    push           = 1'b0;
    in_data        = '0;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    sent           = 0;
    burst          = 1'b0;
    hold_req       = 1'b0;
    hold_done      = 1'b0;
    stall_cycles   = 0;
    phase_cfg = '{16'd0, 16'd65535, 16'd1, 16'd4, 16'd300, 16'd2, 16'd0, 16'd0};
    phase_cfg[6] = 16'($urandom_range(0, 16));
    phase_cfg[7] = 16'($urandom);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    cfg_set(16'd4);
    load(dvvr_pkg::ACT_LOAD_DEV, 0, 32'd0);
    load(dvvr_pkg::ACT_LOAD_DEV, 1, 32'hFFFF_FFFF);   // most negative deviation
    load(dvvr_pkg::ACT_LOAD_DEV, 2, 32'hFFFF_FFFE);   // most positive deviation
    load(dvvr_pkg::ACT_LOAD_DEV, 4095, $urandom);     // beyond the row table, dropped
    send_other();
    load(dvvr_pkg::ACT_LOAD_TS, 0, 32'd5);
    load(dvvr_pkg::ACT_LOAD_TS, 1, 32'd10);
    load(dvvr_pkg::ACT_LOAD_TS, 2, 32'd10);
    load(dvvr_pkg::ACT_LOAD_TS, 3, 32'd20);
    query(0, 1'b1, 32'd10);
    query(0, 1'b1, 32'd0);
    query(0, 1'b1, 32'hFFFF_FFFF);
    query(1, 1'b0, 32'd0);                  // end falls below zero
    query(2, 1'b1, 32'd7);                  // begin below zero, end far above
    load(dvvr_pkg::ACT_LOAD_DEV, 5, 32'd6);
    load(dvvr_pkg::ACT_LOAD_DEV, 6, 32'd15);
    query(6, 1'b1, 32'd7);                  // begin past end
    load(dvvr_pkg::ACT_LOAD_DEV, 1022, 32'd0);
    load(dvvr_pkg::ACT_LOAD_DEV, 1023, 32'd0);
    query(1023, 1'b0, 32'd0);               // end lands on the table size
    query(1023, 1'b1, 32'd515);

    for (int p = 0; p < PHASES; p++) begin
      cfg_set(phase_cfg[p]);
      burst     = ($urandom_range(0, 2) == 0);
      hold_req  = (p == 3);
      phase_end = sent + (ITEMS - sent) / (PHASES - p);
      while (sent < phase_end) random_step();
    end

    push <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("dense_version_value_range_unit: match");
    end else begin
      $display("dense_version_value_range_unit: mismatch");
    end
    $finish;
  end

endmodule
